### rtl/core/ipvhf_pkg.sv
`default_nettype none

package ipvhf_pkg;

  // field offsets within the ipv4 header
  localparam logic [15:0] OffVerIhl   = 16'd0;
  localparam logic [15:0] OffTotHi    = 16'd2;
  localparam logic [15:0] OffTotLo    = 16'd3;
  localparam logic [15:0] OffFragHi   = 16'd6;
  localparam logic [15:0] OffFragLo   = 16'd7;
  localparam logic [15:0] OffDestFrst = 16'd16;
  localparam logic [15:0] OffDestLast = 16'd19;
  localparam logic [15:0] MinHdrBytes = 16'd20;

  localparam logic [3:0]  Ipv4Version = 4'd4;
  localparam logic [15:0] MfFlag      = 16'h2000;
  localparam logic [15:0] OffsetMask  = 16'h1fff;
  localparam logic [31:0] AllOnesAddr = 32'hffff_ffff;
  localparam logic [15:0] SumGood     = 16'hffff;

  typedef enum logic [1:0] {
    CfgIfacePresent = 2'd0,
    CfgLocalAddr    = 2'd1,
    CfgBcastAddr    = 2'd2
  } cfg_index_e;

  typedef enum logic [3:0] {
    VerdictAccept    = 4'd0,
    VerdictShort     = 4'd1,
    VerdictVersion   = 4'd2,
    VerdictHdrLen    = 4'd3,
    VerdictChecksum  = 4'd4,
    VerdictTotLen    = 4'd5,
    VerdictFragment  = 4'd6,
    VerdictNoIface   = 4'd7,
    VerdictOtherHost = 4'd8
  } verdict_e;

  // everything captured from one packet, handed to the verdict stage
  typedef struct packed {
    logic [15:0] count;
    logic [15:0] sum;
    logic [3:0]  version;
    logic [3:0]  ihl;
    logic [15:0] total;
    logic [15:0] frag;
    logic [31:0] dest;
  } pkt_sum_t;

  // interface configuration seen by the verdict stage
  typedef struct packed {
    logic        iface_present;
    logic [31:0] local_addr;
    logic [31:0] bcast_addr;
  } iface_cfg_t;

endpackage

`default_nettype wire

### rtl/core/ipv4_header_receive_filter.sv
// ipv4 receive header filter
// in channel: one packet byte per request (packet_byte_i, last_byte_i), valid/ready.
// while in_ready_o is high each byte is taken as it is offered, so a packet streams in at
// one byte per clock. the header fields, byte count and ones'-complement header sum
// are updated as each byte arrives.
// out channel: exactly one result per packet, produced by the request that
// carries last_byte_i: verdict, header length in bytes, total length field
// and received byte count (saturating at 65535).
// the result is registered first in the capture stage and then in the verdict
// register before it is presented.
// throughput: one byte per cycle, including back-to-back packets, while the output is not stalled.
// stall: with out_ready_i low the result is held; one more packet can finish
// into the capture stage, after which in_ready_o drops until the result leaves.
// config channel: index 0 interface present, 1 local address, 2 broadcast
// address; always ready; to be written only while the filter is idle, which the block does not enforce.
// reset: all configuration and per-packet state clear, no result pending.
`default_nettype none

module ipv4_header_receive_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  packet_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       verdict_o,
  output logic [5:0]       header_bytes_o,
  output logic [15:0]      total_length_o,
  output logic [15:0]      received_length_o
);
  import ipvhf_pkg::*;

  iface_cfg_t cfg_q;
  logic       sum_valid;
  logic       sum_ready;
  pkt_sum_t   pkt_sum;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgIfacePresent: cfg_q.iface_present <= cfg_data_i[0];
        CfgLocalAddr:    cfg_q.local_addr    <= cfg_data_i;
        CfgBcastAddr:    cfg_q.bcast_addr    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ipvhf_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .packet_byte_i (packet_byte_i),
    .last_byte_i   (last_byte_i),
    .sum_valid_o   (sum_valid),
    .sum_ready_i   (sum_ready),
    .sum_o         (pkt_sum)
  );

  ipvhf_judge u_judge (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .sum_valid_i       (sum_valid),
    .sum_ready_o       (sum_ready),
    .sum_i             (pkt_sum),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .verdict_o         (verdict_o),
    .header_bytes_o    (header_bytes_o),
    .total_length_o    (total_length_o),
    .received_length_o (received_length_o)
  );

endmodule

`default_nettype wire

### rtl/core/ipvhf_accum.sv
`default_nettype none

module ipvhf_accum (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        packet_byte_i,
  input  wire logic              last_byte_i,
  output logic                   sum_valid_o,
  input  wire logic              sum_ready_i,
  output ipvhf_pkg::pkt_sum_t    sum_o
);
  import ipvhf_pkg::*;

  logic [15:0] count_q, count_d;
  logic [15:0] acc_q, acc_d;
  logic [7:0]  hold_q, hold_d;
  logic [3:0]  version_q, version_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [15:0] total_q, total_d;
  logic [15:0] frag_q, frag_d;
  logic [31:0] dest_q, dest_d;

  logic        sum_valid_q;
  pkt_sum_t    sum_q;

  logic        accept;
  logic [5:0]  hdr_bytes;
  logic [16:0] add_raw;
  logic [15:0] add_fold;

  assign in_ready_o = !sum_valid_q || sum_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign add_raw  = {1'b0, acc_q} + {1'b0, hold_q, packet_byte_i};
  assign add_fold = add_raw[15:0] + {15'd0, add_raw[16]};

  always_comb begin
    version_d = version_q;
    ihl_d     = ihl_q;
    total_d   = total_q;
    frag_d    = frag_q;
    dest_d    = dest_q;
    hold_d    = hold_q;
    acc_d     = acc_q;

    if (count_q == OffVerIhl) begin
      version_d = packet_byte_i[7:4];
      ihl_d     = packet_byte_i[3:0];
    end else if (count_q == OffTotHi) begin
      total_d = {packet_byte_i, 8'h00};
    end else if (count_q == OffTotLo) begin
      total_d = {total_q[15:8], packet_byte_i};
    end else if (count_q == OffFragHi) begin
      frag_d = {packet_byte_i, 8'h00};
    end else if (count_q == OffFragLo) begin
      frag_d = {frag_q[15:8], packet_byte_i};
    end else if (count_q >= OffDestFrst && count_q <= OffDestLast) begin
      dest_d = {dest_q[23:0], packet_byte_i};
    end

    // header length takes effect from the very first byte
    hdr_bytes = {ihl_d, 2'b00};
    if (count_q < {10'd0, hdr_bytes}) begin
      if (!count_q[0]) begin
        hold_d = packet_byte_i;
      end else begin
        acc_d = add_fold;
      end
    end

    count_d = (count_q != '1) ? count_q + 16'd1 : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      acc_q     <= '0;
      hold_q    <= '0;
      version_q <= '0;
      ihl_q     <= '0;
      total_q   <= '0;
      frag_q    <= '0;
      dest_q    <= '0;
    end else if (accept) begin
      if (last_byte_i) begin
        count_q   <= '0;
        acc_q     <= '0;
        hold_q    <= '0;
        version_q <= '0;
        ihl_q     <= '0;
        total_q   <= '0;
        frag_q    <= '0;
        dest_q    <= '0;
      end else begin
        count_q   <= count_d;
        acc_q     <= acc_d;
        hold_q    <= hold_d;
        version_q <= version_d;
        ihl_q     <= ihl_d;
        total_q   <= total_d;
        frag_q    <= frag_d;
        dest_q    <= dest_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (accept && last_byte_i) begin
      sum_valid_q <= 1'b1;
    end else if (sum_ready_i) begin
      sum_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_byte_i) begin
      sum_q.count   <= count_d;
      sum_q.sum     <= acc_d;
      sum_q.version <= version_d;
      sum_q.ihl     <= ihl_d;
      sum_q.total   <= total_d;
      sum_q.frag    <= frag_d;
      sum_q.dest    <= dest_d;
    end
  end

  assign sum_valid_o = sum_valid_q;
  assign sum_o       = sum_q;

  // per-packet state starts over after the last byte
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_byte_i |=> count_q == '0 && acc_q == '0 && dest_q == '0)
    else $error("packet state not cleared after last byte");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !last_byte_i && count_q != '1 |=> count_q == $past(count_q) + 16'd1)
    else $error("byte count did not advance");

  a_sum_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_valid_q && !sum_ready_i |=> sum_valid_q && $stable(sum_q))
    else $error("packet summary lost while stalled");

endmodule

`default_nettype wire

### rtl/core/ipvhf_judge.sv
`default_nettype none

module ipvhf_judge (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ipvhf_pkg::iface_cfg_t cfg_i,
  input  wire logic                 sum_valid_i,
  output logic                      sum_ready_o,
  input  wire ipvhf_pkg::pkt_sum_t  sum_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [3:0]                verdict_o,
  output logic [5:0]                header_bytes_o,
  output logic [15:0]               total_length_o,
  output logic [15:0]               received_length_o
);
  import ipvhf_pkg::*;

  verdict_e    verdict_d, verdict_q;
  logic [5:0]  hdr_bytes;
  logic [5:0]  hdr_q;
  logic [15:0] total_q;
  logic [15:0] count_q;
  logic        out_valid_q;
  logic        load;

  assign hdr_bytes   = {sum_i.ihl, 2'b00};
  assign sum_ready_o = !out_valid_q || out_ready_i;
  assign load        = sum_valid_i && sum_ready_o;

  // first failing check wins
  always_comb begin
    if (sum_i.count < MinHdrBytes) begin
      verdict_d = VerdictShort;
    end else if (sum_i.version != Ipv4Version) begin
      verdict_d = VerdictVersion;
    end else if (sum_i.count < {10'd0, hdr_bytes}) begin
      verdict_d = VerdictHdrLen;
    end else if (sum_i.sum != SumGood) begin
      verdict_d = VerdictChecksum;
    end else if (sum_i.count < sum_i.total) begin
      verdict_d = VerdictTotLen;
    end else if ((sum_i.frag & (MfFlag | OffsetMask)) != '0) begin
      verdict_d = VerdictFragment;
    end else if (!cfg_i.iface_present) begin
      verdict_d = VerdictNoIface;
    end else if (sum_i.dest != cfg_i.local_addr && sum_i.dest != cfg_i.bcast_addr &&
                 sum_i.dest != AllOnesAddr) begin
      verdict_d = VerdictOtherHost;
    end else begin
      verdict_d = VerdictAccept;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      verdict_q <= verdict_d;
      hdr_q     <= hdr_bytes;
      total_q   <= sum_i.total;
      count_q   <= sum_i.count;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign verdict_o         = verdict_q;
  assign header_bytes_o    = hdr_q;
  assign total_length_o    = total_q;
  assign received_length_o = count_q;

endmodule

`default_nettype wire
